>>> rtl/core/lpht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants of the linear-probe hash table
// Widths, operation and status codes, queue and slot layouts.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int unsigned INDEX_BITS  = 10;
  localparam int unsigned TABLE_SIZE  = 1 << INDEX_BITS;
  localparam int unsigned COUNT_W     = INDEX_BITS + 1;
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned VALUE_W     = 10;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned IN_DATA_W   = 80;
  localparam int unsigned OUT_DATA_W  = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS     = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_DISABLED = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_CLEARED  = 3'd4;

  typedef enum logic [1:0] {
    CMD_LOOKUP,
    CMD_INSERT,
    CMD_CLEAR,
    CMD_NONE
  } cmd_e;

  typedef enum logic [1:0] {
    BK_SWEEP,
    BK_IDLE,
    BK_PROBE
  } back_state_e;

  typedef struct packed {
    cmd_e                  cmd;
    logic [KEY_W-1:0]      key;
    logic [VALUE_W-1:0]    value;
    logic [INDEX_BITS-1:0] home;
  } req_t;

  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
    logic [KEY_W-1:0]   key;
  } slot_t;

endpackage
`default_nettype wire

>>> rtl/core/lpht_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_front: input stage
// Accepts items, decodes the operation, works out the home slot and holds
// the classified request until the queue takes it.
// ----------------------------------------------------------------------------
module lpht_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [lpht_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // key, value_in, zero pad
  input  wire logic [lpht_pkg::OP_W-1:0]         s_axis_tuser,  // operation
  input  wire logic                              clearing_i,
  output logic                                   push_valid_o,
  input  wire logic                              push_ready_i,
  output lpht_pkg::req_t                         push_data_o
);

  lpht_pkg::req_t  hold_q, hold_d, req_in;
  logic            hold_valid_q, hold_valid_d;
  logic            accept;

  always_comb begin
    req_in.key   = s_axis_tdata[lpht_pkg::KEY_W-1:0];
    req_in.value = s_axis_tdata[lpht_pkg::KEY_W +: lpht_pkg::VALUE_W];
    req_in.home  = s_axis_tdata[lpht_pkg::INDEX_BITS-1:0];
    unique case (s_axis_tuser)
      lpht_pkg::OP_LOOKUP: req_in.cmd = lpht_pkg::CMD_LOOKUP;
      lpht_pkg::OP_INSERT: req_in.cmd = lpht_pkg::CMD_INSERT;
      lpht_pkg::OP_CLEAR:  req_in.cmd = lpht_pkg::CMD_CLEAR;
      default:             req_in.cmd = lpht_pkg::CMD_NONE;
    endcase
  end

  // take no item while the table is being swept
  assign s_axis_tready = (!hold_valid_q || push_ready_i) && !clearing_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push_valid_o  = hold_valid_q;
  assign push_data_o   = hold_q;

  always_comb begin
    hold_d       = hold_q;
    hold_valid_d = hold_valid_q;
    if (accept) begin
      hold_d       = req_in;
      hold_valid_d = 1'b1;
    end else if (push_ready_i) begin
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

endmodule
`default_nettype wire

>>> rtl/core/lpht_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_queue: request queue
// Short first-in first-out buffer between the front and the probe engine.
// ----------------------------------------------------------------------------
module lpht_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire lpht_pkg::req_t push_data_i,
  output logic                head_valid_o,
  input  wire logic           pop_i,
  output lpht_pkg::req_t      head_data_o
);

  lpht_pkg::req_t               entry_q [lpht_pkg::QUEUE_DEPTH];
  logic [lpht_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [lpht_pkg::QCNT_W-1:0]  count_q, count_d;
  logic                         push, pop;

  assign push_ready_o = (count_q != lpht_pkg::QCNT_W'(lpht_pkg::QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_data_o  = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + lpht_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - lpht_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + lpht_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + lpht_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= lpht_pkg::QCNT_W'(lpht_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + lpht_pkg::QCNT_W'(1)))
    else $error("queue count did not follow a push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");

endmodule
`default_nettype wire

>>> rtl/core/lpht_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_back: probe engine
// Holds the slot memory, walks the probe chain one slot a cycle, performs
// inserts and clearing sweeps, and registers the result item.
// ----------------------------------------------------------------------------
module lpht_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             head_valid_i,
  output logic                                  pop_o,
  input  wire lpht_pkg::req_t                   head_data_i,
  output logic                                  clearing_o,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [lpht_pkg::OUT_DATA_W-1:0]       m_axis_tdata,  // value_out, zero pad
  output logic [lpht_pkg::STATUS_W-1:0]         m_axis_tuser   // status
);

  lpht_pkg::back_state_e state_q, state_d;

  lpht_pkg::slot_t               mem [lpht_pkg::TABLE_SIZE];
  lpht_pkg::slot_t               rd_q, wr_data;
  logic [lpht_pkg::INDEX_BITS-1:0] rd_addr, wr_addr;
  logic                          wr_en;

  lpht_pkg::req_t                req_q, req_d;
  logic [lpht_pkg::INDEX_BITS-1:0] idx_q, idx_d, cnt_q, cnt_d, sweep_q, sweep_d;
  logic                          reply_q, reply_d;
  logic                          disabled_q, disabled_d;
  logic [lpht_pkg::COUNT_W-1:0]  entry_count_q, entry_count_d;
  logic                          out_valid_q, out_valid_d;
  logic [lpht_pkg::VALUE_W-1:0]  out_value_q, out_value_d;
  logic [lpht_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic                          out_free, slot_hit, slot_empty;

  assign out_free   = !out_valid_q || m_axis_tready;
  assign slot_hit   = rd_q.valid && (rd_q.key == req_q.key);
  assign slot_empty = !rd_q.valid;
  assign clearing_o = (state_q == lpht_pkg::BK_SWEEP);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(lpht_pkg::OUT_DATA_W - lpht_pkg::VALUE_W){1'b0}}, out_value_q};
  assign m_axis_tuser  = out_status_q;

  always_comb begin
    state_d       = state_q;
    req_d         = req_q;
    idx_d         = idx_q;
    cnt_d         = cnt_q;
    sweep_d       = sweep_q;
    reply_d       = reply_q;
    disabled_d    = disabled_q;
    entry_count_d = entry_count_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_value_d   = out_value_q;
    out_status_d  = out_status_q;
    pop_o         = 1'b0;
    rd_addr       = idx_q;
    wr_en         = 1'b0;
    wr_addr       = idx_q;
    wr_data       = '0;

    unique case (state_q)
      lpht_pkg::BK_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = sweep_q;
        sweep_d = sweep_q + lpht_pkg::INDEX_BITS'(1);
        if (sweep_q == {lpht_pkg::INDEX_BITS{1'b1}}) begin
          state_d       = lpht_pkg::BK_IDLE;
          disabled_d    = 1'b0;
          entry_count_d = '0;
          reply_d       = 1'b0;
          if (reply_q) begin
            out_valid_d  = 1'b1;
            out_value_d  = '0;
            out_status_d = lpht_pkg::STATUS_CLEARED;
          end
        end
      end

      lpht_pkg::BK_IDLE: begin
        rd_addr = head_data_i.home;
        if (head_valid_i && out_free) begin
          pop_o = 1'b1;
          req_d = head_data_i;
          idx_d = head_data_i.home;
          cnt_d = '0;
          unique case (head_data_i.cmd)
            lpht_pkg::CMD_LOOKUP: begin
              if (disabled_q) begin
                out_valid_d  = 1'b1;
                out_value_d  = '0;
                out_status_d = lpht_pkg::STATUS_DISABLED;
              end else begin
                state_d = lpht_pkg::BK_PROBE;
              end
            end
            lpht_pkg::CMD_INSERT: begin
              state_d = lpht_pkg::BK_PROBE;
            end
            lpht_pkg::CMD_CLEAR: begin
              state_d = lpht_pkg::BK_SWEEP;
              sweep_d = '0;
              reply_d = 1'b1;
            end
            lpht_pkg::CMD_NONE: begin
              out_valid_d  = 1'b1;
              out_value_d  = '0;
              out_status_d = lpht_pkg::STATUS_MISS;
            end
          endcase
        end
      end

      lpht_pkg::BK_PROBE: begin
        if (slot_hit || slot_empty) begin
          state_d     = lpht_pkg::BK_IDLE;
          out_valid_d = 1'b1;
          out_value_d = '0;
          if (req_q.cmd == lpht_pkg::CMD_INSERT) begin
            wr_en         = 1'b1;
            wr_data.valid = 1'b1;
            wr_data.value = req_q.value;
            wr_data.key   = req_q.key;
            if (slot_empty) begin
              entry_count_d = entry_count_q + lpht_pkg::COUNT_W'(1);
            end
            out_status_d = lpht_pkg::STATUS_OK;
          end else if (slot_hit) begin
            out_value_d  = rd_q.value;
            out_status_d = lpht_pkg::STATUS_OK;
          end else begin
            disabled_d   = 1'b1;
            out_status_d = lpht_pkg::STATUS_MISS;
          end
        end else if (cnt_q == {lpht_pkg::INDEX_BITS{1'b1}}) begin
          // full pass without a free slot or a match
          state_d     = lpht_pkg::BK_IDLE;
          out_valid_d = 1'b1;
          out_value_d = '0;
          if (req_q.cmd == lpht_pkg::CMD_INSERT) begin
            out_status_d = lpht_pkg::STATUS_FULL;
          end else begin
            disabled_d   = 1'b1;
            out_status_d = lpht_pkg::STATUS_MISS;
          end
        end else begin
          // advance to the next slot, wrapping at the table size
          idx_d   = idx_q + lpht_pkg::INDEX_BITS'(1);
          cnt_d   = cnt_q + lpht_pkg::INDEX_BITS'(1);
          rd_addr = idx_d;
        end
      end

      default: begin
        state_d = lpht_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpht_pkg::BK_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q       <= '0;
      reply_q       <= 1'b0;
      disabled_q    <= 1'b0;
      entry_count_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      sweep_q       <= sweep_d;
      reply_q       <= reply_d;
      disabled_q    <= disabled_d;
      entry_count_q <= entry_count_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    idx_q        <= idx_d;
    cnt_q        <= cnt_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_q <= lpht_pkg::COUNT_W'(lpht_pkg::TABLE_SIZE))
    else $error("entry count beyond table size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == lpht_pkg::BK_IDLE && out_free))
    else $error("request taken while engine busy or result pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && state_q == lpht_pkg::BK_PROBE) |-> (req_q.cmd == lpht_pkg::CMD_INSERT))
    else $error("slot written by a request other than insert");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpht_pkg::BK_PROBE && slot_empty && req_q.cmd == lpht_pkg::CMD_LOOKUP)
      |=> disabled_q)
    else $error("lookup miss did not disable lookups");

endmodule
`default_nettype wire

>>> rtl/core/linear_probe_hash_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Operation: a lookup or insert probes k slots (1 to 1024) of the memory; a
//   disabled lookup or unused code probes none, and a clear writes every slot
//   (one memory write a slot) before it gives its result.
// Throughput: the probe engine picks up an item and then reads one slot of the
//   memory a cycle; it takes no new item before it is through with the last one.
// Reset: a clearing pass runs after reset; no item is taken during it.
// ----------------------------------------------------------------------------
// linear_probe_hash_table: open-addressing hash table with linear probing
// Keyed by a 64-bit hash, holds a 10-bit value per key; supports lookup,
// insert and clear, with lookups disabled after a lookup miss until the next clear.
// ----------------------------------------------------------------------------
module linear_probe_hash_table (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [lpht_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // key[63:0], value_in[73:64], pad
  input  wire logic [lpht_pkg::OP_W-1:0]        s_axis_tuser,  // operation[1:0]
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [lpht_pkg::OUT_DATA_W-1:0]       m_axis_tdata,  // value_out[9:0], pad
  output logic [lpht_pkg::STATUS_W-1:0]         m_axis_tuser   // status[2:0]
);

  logic           push_valid, push_ready, head_valid, pop, clearing;
  lpht_pkg::req_t push_data, head_data;

  lpht_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .clearing_i    (clearing),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_data_o   (push_data)
  );

  lpht_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_data_o  (head_data)
  );

  lpht_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .pop_o         (pop),
    .head_data_i   (head_data),
    .clearing_o    (clearing),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
`default_nettype wire
